// ----- hdl/psched_pkg.sv -----
`default_nettype none
package psched_pkg;

	localparam int MAX_TASKS_DEF = 32;
	localparam int TIME_W        = 24;
	localparam int ARR_W         = 16;
	localparam int WORK_W        = 18;
	localparam int WT_W          = 16;
	localparam int SUM_W         = 21;
	localparam int SLICE_W       = 16;
	localparam int QUANT_W       = 8;
	localparam int NUM_W         = 32;
	localparam int TASKNUM_W     = 6;
	localparam int ENTRY_W       = ARR_W + WORK_W + WT_W;

	localparam logic [QUANT_W-1:0] QUANTUM_RST = 8'd10;
	localparam logic [WORK_W-1:0]  ONE_Q8      = 18'd256;
	localparam logic [TIME_W-1:0]  TIME_MAX    = 24'hFFFFFF;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_LOAD  = 2'd1;
	localparam logic [1:0] ACT_STEP  = 2'd2;

	localparam logic [1:0] EV_RUN  = 2'd0;
	localparam logic [1:0] EV_IDLE = 2'd1;
	localparam logic [1:0] EV_DONE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_CHK,
		ST_DIV,
		ST_WB,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

// ----- hdl/psched_ram.sv -----
`default_nettype none
module psched_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- hdl/psched_div.sv -----
`default_nettype none
module psched_div
	import psched_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [SUM_W-1:0] den,
	output logic                  done,
	output logic      [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W:0]   rem_q;
	logic [NUM_W-1:0] quo_q;
	logic             done_q;
	logic [SUM_W:0]   trial;
	logic             take;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q[SUM_W-1:0], quo_q[NUM_W-1]};
	assign take  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= take ? (trial - {1'b0, den}) : trial;
			quo_q <= {quo_q[NUM_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

// ----- hdl/proportional_share_scheduler.sv -----
`default_nettype none
// weighted round-robin scheduler over a table of up to MAX_TASKS tasks held in one
// synchronous memory (arrival, remaining work q10.8, weight q8.8). clear and load
// transactions complete in the idle state. a step transaction scans the table from
// the cursor, reading each entry from memory and then checking it for readiness,
// at most twice around the table; when a ready task is found its slice
// weight*quantum*256/live_weight_sum comes from a bit-serial divider, followed by
// a write-back state and then a state that posts the result. a step on an empty or
// finished table returns a done event. a result waits in the output register until
// taken while the next transaction is accepted. the quantum register is written
// through the cfg channel, which is always ready.
module proportional_share_scheduler
	import psched_pkg::*;
#(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [QUANT_W-1:0]   cfg_quantum,
	// input transactions
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           action,
	input  wire logic [ARR_W-1:0]     arrival_time,
	input  wire logic [WORK_W-1:0]    work_q8,
	input  wire logic [WT_W-1:0]      weight_q8,
	// result transactions
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [1:0]           event_kind,
	output logic      [TASKNUM_W-1:0] task_number,
	output logic      [TIME_W-1:0]    start_time,
	output logic      [SLICE_W-1:0]   slice_q8,
	output logic                      task_finished,
	output logic      [TIME_W-1:0]    end_time
);

	localparam int IW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int WQ_W = WT_W + QUANT_W;

	// table layout in memory: arrival | remaining | weight
	localparam int REM_LO = WT_W;
	localparam int ARR_LO = WT_W + WORK_W;

	state_t state_q, state_d;

	logic [QUANT_W-1:0] quantum_q;
	logic [CW-1:0]      task_cnt_q;
	logic [CW-1:0]      fin_cnt_q;
	logic [IW-1:0]      cursor_q;
	logic               rhr_q;       // current round has seen a ready task
	logic [TIME_W-1:0]  now_q;
	logic [SUM_W-1:0]   wsum_q;

	logic [IW-1:0]      idx_q;
	logic               wrapped_q;
	logic [ARR_W-1:0]   arr_q;
	logic [WORK_W-1:0]  rem_q;
	logic [WT_W-1:0]    wt_q;

	// pending result, waits here until the output register is free
	logic [1:0]           res_kind_q;
	logic [TASKNUM_W-1:0] res_task_q;
	logic [TIME_W-1:0]    res_start_q;
	logic [SLICE_W-1:0]   res_slice_q;
	logic                 res_fin_q;
	logic [TIME_W-1:0]    res_end_q;

	logic                 out_valid_q;
	logic [1:0]           ev_kind_q;
	logic [TASKNUM_W-1:0] task_num_q;
	logic [TIME_W-1:0]    start_q;
	logic [SLICE_W-1:0]   slice_out_q;
	logic                 fin_out_q;
	logic [TIME_W-1:0]    end_q;

	// memory port signals
	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [IW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	// divider
	logic               div_start;
	logic [NUM_W-1:0]   div_num;
	logic               div_done;
	logic [NUM_W-1:0]   div_quo;

	logic               in_fire;
	logic               out_free;
	logic [ARR_W-1:0]   rd_arr;
	logic [WORK_W-1:0]  rd_rem;
	logic [WT_W-1:0]    rd_wt;
	logic               entry_ready;
	logic [CW-1:0]      idx_p1;
	logic               at_last;
	logic               table_full;
	logic               all_done;
	logic [WORK_W-1:0]  load_work;
	logic [WQ_W-1:0]    wq_prod;
	logic [NUM_W-1:0]   quo_eff;
	logic [SLICE_W-1:0] slice;
	logic               fin_now;
	logic [WORK_W-1:0]  rem_new;
	logic [9:0]         delta;
	logic [TIME_W:0]    time_sum;
	logic [TIME_W-1:0]  now_run;
	logic [TIME_W-1:0]  now_inc;
	logic [31:0]        task_num_w;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign rd_arr      = ram_rdata[ARR_LO +: ARR_W];
	assign rd_rem      = ram_rdata[REM_LO +: WORK_W];
	assign rd_wt       = ram_rdata[0 +: WT_W];
	assign entry_ready = (rd_rem != '0) && ({8'd0, rd_arr} <= now_q);

	assign idx_p1     = CW'(idx_q) + CW'(1);
	assign at_last    = idx_p1 >= task_cnt_q;
	assign table_full = task_cnt_q >= CW'(MAX_TASKS);
	assign all_done   = fin_cnt_q >= task_cnt_q;
	assign load_work  = (work_q8 < ONE_Q8) ? ONE_Q8 : work_q8;
	// full 24-bit weight * quantum product, then scaled by 256
	assign wq_prod    = WQ_W'(rd_wt) * WQ_W'(quantum_q);
	assign div_num    = {wq_prod, 8'd0};

	// slice: zero weight sum counts as quotient zero; clamp to [1.0, 255.996] in q8.8
	always_comb begin
		quo_eff = (wsum_q == '0) ? '0 : div_quo;
		if (quo_eff < NUM_W'(ONE_Q8)) begin
			slice = SLICE_W'(ONE_Q8);
		end else if (quo_eff > NUM_W'(16'hFFFF)) begin
			slice = 16'hFFFF;
		end else begin
			slice = quo_eff[SLICE_W-1:0];
		end
	end

	assign fin_now  = rem_q <= WORK_W'(slice);
	assign rem_new  = fin_now ? '0 : (rem_q - WORK_W'(slice));
	assign delta    = fin_now ? rem_q[WORK_W-1:8] : {2'b00, slice[SLICE_W-1:8]};
	assign time_sum = {1'b0, now_q} + (TIME_W+1)'(delta);
	assign now_run  = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
	assign now_inc  = (now_q == TIME_MAX) ? TIME_MAX : now_q + TIME_W'(1);

	assign task_num_w = 32'(idx_q) + 32'd1;

	// next state and memory / divider controls
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {arr_q, rem_new, wt_q};
		ram_raddr = idx_q;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (action == ACT_LOAD && !table_full) begin
						ram_we    = 1'b1;
						ram_waddr = IW'(task_cnt_q);
						ram_wdata = {arrival_time, load_work, weight_q8};
					end else if (action == ACT_STEP) begin
						state_d = all_done ? ST_EMIT : ST_RD;
					end
				end
			end
			ST_RD: begin
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (entry_ready) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else if (!at_last || (rhr_q && !wrapped_q)) begin
					state_d = ST_RD;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_WB;
				end
			end
			ST_WB: begin
				ram_we  = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q  <= QUANTUM_RST;
			task_cnt_q <= '0;
			fin_cnt_q  <= '0;
			cursor_q   <= '0;
			rhr_q      <= 1'b0;
			now_q      <= '0;
			wsum_q     <= '0;
			idx_q      <= '0;
			wrapped_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				quantum_q <= cfg_quantum;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (action == ACT_CLEAR) begin
							task_cnt_q <= '0;
							fin_cnt_q  <= '0;
							cursor_q   <= '0;
							rhr_q      <= 1'b0;
							now_q      <= '0;
							wsum_q     <= '0;
						end else if (action == ACT_LOAD && !table_full) begin
							task_cnt_q <= task_cnt_q + CW'(1);
							wsum_q     <= wsum_q + SUM_W'(weight_q8);
						end else if (action == ACT_STEP) begin
							idx_q     <= cursor_q;
							wrapped_q <= 1'b0;
						end
					end
				end
				ST_CHK: begin
					if (!entry_ready) begin
						if (!at_last) begin
							idx_q <= IW'(idx_p1);
						end else if (rhr_q && !wrapped_q) begin
							// rest of the round was empty, restart from the top
							idx_q     <= '0;
							wrapped_q <= 1'b1;
							rhr_q     <= 1'b0;
						end else begin
							// nothing ready anywhere: one idle unit
							now_q    <= now_inc;
							cursor_q <= '0;
							rhr_q    <= 1'b0;
						end
					end
				end
				ST_WB: begin
					now_q <= now_run;
					if (fin_now) begin
						fin_cnt_q <= fin_cnt_q + CW'(1);
						wsum_q    <= wsum_q - SUM_W'(wt_q);
					end
					if (at_last) begin
						cursor_q <= '0;
						rhr_q    <= 1'b0;
					end else begin
						cursor_q <= IW'(idx_p1);
						rhr_q    <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// entry latch and pending result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			res_kind_q  <= EV_DONE;
			res_task_q  <= '0;
			res_start_q <= now_q;
			res_slice_q <= '0;
			res_fin_q   <= 1'b0;
			res_end_q   <= now_q;
		end
		if (state_q == ST_CHK) begin
			arr_q <= rd_arr;
			rem_q <= rd_rem;
			wt_q  <= rd_wt;
			res_kind_q  <= EV_IDLE;
			res_task_q  <= '0;
			res_start_q <= now_q;
			res_slice_q <= '0;
			res_fin_q   <= 1'b0;
			res_end_q   <= now_inc;
		end
		if (state_q == ST_WB) begin
			res_kind_q  <= EV_RUN;
			res_task_q  <= task_num_w[TASKNUM_W-1:0];
			res_start_q <= now_q;
			res_slice_q <= slice;
			res_fin_q   <= fin_now;
			res_end_q   <= now_run;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			ev_kind_q   <= res_kind_q;
			task_num_q  <= res_task_q;
			start_q     <= res_start_q;
			slice_out_q <= res_slice_q;
			fin_out_q   <= res_fin_q;
			end_q       <= res_end_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_kind    = ev_kind_q;
	assign task_number   = task_num_q;
	assign start_time    = start_q;
	assign slice_q8      = slice_out_q;
	assign task_finished = fin_out_q;
	assign end_time      = end_q;

	psched_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_TASKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	psched_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (wsum_q),
		.done  (div_done),
		.quo   (div_quo)
	);

`ifndef SYNTHESIS
	a_fin_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		fin_cnt_q <= task_cnt_q)
		else $error("finished count exceeds task count");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		task_cnt_q <= CW'(MAX_TASKS))
		else $error("task count exceeds table size");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |-> CW'(idx_q) < task_cnt_q)
		else $error("scan index beyond loaded tasks");
`endif

endmodule
`default_nettype wire
